// ===== rtl/force_field_evaluate_assert.svh =====
// assertion macros for the force field evaluator
`ifndef FORCE_FIELD_EVALUATE_ASSERT_SVH
`define FORCE_FIELD_EVALUATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define FFE_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("force field check failed");

// next-cycle implication, sampled on clk, off during reset
`define FFE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("force field check failed");

`else

`define FFE_ASSERT_IMPLY(name, ante, cons)
`define FFE_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/ffe_pkg.sv =====
package ffe_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int KIND_W      = 3;

    // field laws
    typedef enum logic [KIND_W-1:0] {
        KIND_GRAVITY = 3'd0,
        KIND_WIND    = 3'd1,
        KIND_VORTEX  = 3'd2,
        KIND_REPEL   = 3'd3,
        KIND_ATTRACT = 3'd4
    } field_kind_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIELD_KIND     = 3'd0,
        CFG_CENTER_X       = 3'd1,
        CFG_CENTER_Y       = 3'd2,
        CFG_FIELD_STRENGTH = 3'd3,
        CFG_CUTOFF_RADIUS  = 3'd4,
        CFG_FIXED_FORCE_X  = 3'd5,
        CFG_FIXED_FORCE_Y  = 3'd6
    } cfg_index_t;

    // per-beat flags that ride alongside the divider and root pipelines
    typedef struct packed {
        logic zero;
        logic beyond;
        logic neg_x;
        logic neg_y;
    } side_t;

endpackage

// ===== rtl/ffe_delay.sv =====
module ffe_delay #(
    parameter int W = 4,
    parameter int N = 2
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [N];

    // plain shift line
    always_ff @(posedge clk)
    begin
        line_reg[0] <= din;
        for (int k = 0; k < N - 1; k++)
        begin
            line_reg[k+1] <= line_reg[k];
        end
    end

    assign dout = line_reg[N-1];

endmodule

// ===== rtl/ffe_div.sv =====
module ffe_div #(
    parameter int NW    = 88,
    parameter int DW    = 65,
    parameter int QW    = 32,
    parameter int LANES = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   num,
    input  logic [LANES-1:0][DW-1:0]   den,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   quo,
    output logic [LANES-1:0]           ovf
);

    localparam int HW = NW - QW;
    localparam int XW = (HW > DW) ? HW : DW;

    logic [QW:0] vld_reg;

    // valid bits, one per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[QW];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [DW-1:0] rem_reg [QW];
        logic [DW-1:0] den_reg [QW];
        logic [QW-1:0] nlo_reg [QW];
        logic [QW-1:0] quo_reg [QW+1];
        logic [QW:0]   ovf_reg;
        logic [DW-1:0] rem_next [QW];
        logic [QW-1:0] quo_next [QW];
        logic [DW:0]   shift [QW];
        logic [QW-1:0] fits;
        logic [XW-1:0] hi_ext;
        logic [XW-1:0] den_ext;

        // quotient overflows when the upper numerator part already reaches the divisor
        assign hi_ext  = XW'(num[g][NW-1:QW]);
        assign den_ext = XW'(den[g]);

        // one restoring step per stage
        always_comb
        begin
            for (int k = 0; k < QW; k++)
            begin
                shift[k] = {rem_reg[k], nlo_reg[k][QW-1]};
                fits[k]  = shift[k] >= {1'b0, den_reg[k]};
                rem_next[k] = fits[k] ? DW'(shift[k] - {1'b0, den_reg[k]}) : DW'(shift[k]);
                quo_next[k] = {quo_reg[k][QW-2:0], fits[k]};
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[0] <= DW'(hi_ext);
            den_reg[0] <= den[g];
            nlo_reg[0] <= num[g][QW-1:0];
            quo_reg[0] <= '0;
            ovf_reg[0] <= hi_ext >= den_ext;
            for (int k = 0; k < QW - 1; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                den_reg[k+1] <= den_reg[k];
                nlo_reg[k+1] <= nlo_reg[k] << 1;
            end
            for (int k = 0; k < QW; k++)
            begin
                quo_reg[k+1] <= quo_next[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        assign quo[g] = quo_reg[QW];
        assign ovf[g] = ovf_reg[QW];
    end

endmodule

// ===== rtl/ffe_sqrt.sv =====
module ffe_sqrt #(
    parameter int VW    = 32,
    parameter int LANES = 1,
    parameter int RW    = (VW + 1) / 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [LANES-1:0][VW-1:0]  val,
    output logic                      out_valid,
    output logic [LANES-1:0][RW-1:0]  root
);

    localparam int PW = 2 * RW;

    logic [RW-1:0] vld_reg;

    // valid bits, one per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[RW-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[RW-1];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [RW:0]   rem_reg  [RW];
        logic [RW-1:0] root_reg [RW];
        logic [PW-1:0] rad_reg  [RW];
        logic [RW:0]   cur_rem  [RW];
        logic [RW-1:0] cur_root [RW];
        logic [PW-1:0] cur_rad  [RW];
        logic [RW+2:0] shift [RW];
        logic [RW+2:0] trial [RW];
        logic [RW-1:0] fits;

        // one result bit per stage, two radicand bits consumed each step
        always_comb
        begin
            cur_rem[0]  = '0;
            cur_root[0] = '0;
            cur_rad[0]  = PW'(val[g]);
            for (int k = 1; k < RW; k++)
            begin
                cur_rem[k]  = rem_reg[k-1];
                cur_root[k] = root_reg[k-1];
                cur_rad[k]  = rad_reg[k-1];
            end
            for (int k = 0; k < RW; k++)
            begin
                shift[k] = {cur_rem[k], cur_rad[k][PW-1:PW-2]};
                trial[k] = (RW + 3)'({cur_root[k], 2'b01});
                fits[k]  = shift[k] >= trial[k];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int k = 0; k < RW; k++)
            begin
                rem_reg[k]  <= fits[k] ? (RW + 1)'(shift[k] - trial[k]) : (RW + 1)'(shift[k]);
                root_reg[k] <= {cur_root[k][RW-2:0], fits[k]};
                rad_reg[k]  <= cur_rad[k] << 2;
            end
        end

        assign root[g] = root_reg[RW-1];
    end

endmodule

// ===== rtl/force_field_evaluate.sv =====
// throughput: one position per cycle, busy stays low; latency is set by the
//   bit-per-stage divider pipeline (QW = max(COORD_WIDTH, 2*FRAC_BITS+1) bits)
//   followed by the digit-per-stage root pipeline
// reset: rst_n clears all configuration registers to zero and empties the pipeline
// done pulses for one cycle per result; the receiver cannot stall
`include "force_field_evaluate_assert.svh"

module force_field_evaluate #(
    parameter int FRAC_BITS   = 12,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ffe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       pos_x,
    input  logic signed [COORD_WIDTH-1:0]       pos_y,
    output logic                                done,
    output logic signed [COORD_WIDTH-1:0]       force_x,
    output logic signed [COORD_WIDTH-1:0]       force_y,
    output logic                                clipped
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * CW + 1;
    localparam int NW  = 2 * CW + 2 * F;
    localparam int QW  = (CW > 2 * F + 1) ? CW : 2 * F + 1;
    localparam int RW  = (QW + 1) / 2;
    localparam int MW  = RW + QW;
    localparam int LAT = 7 + QW + RW;
    localparam int SW  = $bits(ffe_pkg::side_t);

    // configuration registers
    logic [ffe_pkg::KIND_W-1:0] kind_reg;
    logic signed [CW-1:0]       cx_reg;
    logic signed [CW-1:0]       cy_reg;
    logic signed [CW-1:0]       str_reg;
    logic [CW-2:0]              rad_reg;
    logic [CW-1:0]              ffx_reg;
    logic [CW-1:0]              ffy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            str_reg  <= '0;
            rad_reg  <= '0;
            ffx_reg  <= '0;
            ffy_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffe_pkg::CFG_FIELD_KIND:     kind_reg <= cfg_data[ffe_pkg::KIND_W-1:0];
                ffe_pkg::CFG_CENTER_X:       cx_reg   <= cfg_data;
                ffe_pkg::CFG_CENTER_Y:       cy_reg   <= cfg_data;
                ffe_pkg::CFG_FIELD_STRENGTH: str_reg  <= cfg_data;
                ffe_pkg::CFG_CUTOFF_RADIUS:  rad_reg  <= cfg_data[CW-2:0];
                ffe_pkg::CFG_FIXED_FORCE_X:  ffx_reg  <= cfg_data;
                ffe_pkg::CFG_FIXED_FORCE_Y:  ffy_reg  <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // static decode of the field law
    logic          is_const;
    logic          is_vortex;
    logic          is_radial;
    logic          sneg;
    logic          rneg;
    logic [CW-1:0] as_mag;

    assign is_const  = (kind_reg == ffe_pkg::KIND_GRAVITY) || (kind_reg == ffe_pkg::KIND_WIND);
    assign is_vortex = kind_reg == ffe_pkg::KIND_VORTEX;
    assign is_radial = (kind_reg == ffe_pkg::KIND_REPEL) || (kind_reg == ffe_pkg::KIND_ATTRACT);
    assign sneg      = str_reg[CW-1];
    assign rneg      = sneg != (kind_reg == ffe_pkg::KIND_REPEL);
    assign as_mag    = sneg ? CW'(-str_reg) : CW'(str_reg);

    assign busy = 1'b0;

    // stage 1: offsets and their magnitudes
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic               dx_neg;
    logic               dy_neg;
    logic               dy_pos;
    logic               v1_reg;
    logic [CW-1:0]      ax1_reg;
    logic [CW-1:0]      ay1_reg;
    logic               nx1_reg;
    logic               ny1_reg;

    always_comb
    begin
        if (is_vortex)
        begin
            dx = {pos_x[CW-1], pos_x} - {cx_reg[CW-1], cx_reg};
            dy = {pos_y[CW-1], pos_y} - {cy_reg[CW-1], cy_reg};
        end
        else
        begin
            dx = {cx_reg[CW-1], cx_reg} - {pos_x[CW-1], pos_x};
            dy = {cy_reg[CW-1], cy_reg} - {pos_y[CW-1], pos_y};
        end
        dx_neg = dx[CW];
        dy_neg = dy[CW];
        dy_pos = !dy[CW] && (dy != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        ax1_reg <= dx_neg ? CW'(-dx) : CW'(dx);
        ay1_reg <= dy_neg ? CW'(-dy) : CW'(dy);
        nx1_reg <= is_vortex ? (dy_pos != sneg) : (dx_neg != rneg);
        ny1_reg <= is_vortex ? (dx_neg != sneg) : (dy_neg != rneg);
    end

    // stage 2: squares and strength products
    logic                v2_reg;
    logic [2*CW-1:0]     pxx2_reg;
    logic [2*CW-1:0]     pyy2_reg;
    logic [2*CW-1:0]     pxs2_reg;
    logic [2*CW-1:0]     pys2_reg;
    logic [2*CW-3:0]     r2_reg;
    logic                zero2_reg;
    logic                nx2_reg;
    logic                ny2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pxx2_reg  <= (2 * CW)'(ax1_reg) * (2 * CW)'(ax1_reg);
        pyy2_reg  <= (2 * CW)'(ay1_reg) * (2 * CW)'(ay1_reg);
        pxs2_reg  <= (2 * CW)'(ax1_reg) * (2 * CW)'(as_mag);
        pys2_reg  <= (2 * CW)'(ay1_reg) * (2 * CW)'(as_mag);
        r2_reg    <= (2 * CW - 2)'(rad_reg) * (2 * CW - 2)'(rad_reg);
        zero2_reg <= (ax1_reg == '0) && (ay1_reg == '0);
        nx2_reg   <= nx1_reg;
        ny2_reg   <= ny1_reg;
    end

    // stage 3: squared distance
    logic                v3_reg;
    logic [DW-1:0]       sraw3_reg;
    logic [2*CW-1:0]     pxx3_reg;
    logic [2*CW-1:0]     pyy3_reg;
    logic [2*CW-1:0]     pxs3_reg;
    logic [2*CW-1:0]     pys3_reg;
    logic                zero3_reg;
    logic                nx3_reg;
    logic                ny3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sraw3_reg <= DW'(pxx2_reg) + DW'(pyy2_reg);
        pxx3_reg  <= pxx2_reg;
        pyy3_reg  <= pyy2_reg;
        pxs3_reg  <= pxs2_reg;
        pys3_reg  <= pys2_reg;
        zero3_reg <= zero2_reg;
        nx3_reg   <= nx2_reg;
        ny3_reg   <= ny2_reg;
    end

    // stage 4: clamp, radius test and divider operands
    logic [DW-1:0]             scl;
    logic                      v4_reg;
    logic [2:0][NW-1:0]        num4_reg;
    logic [2:0][DW-1:0]        den4_reg;
    ffe_pkg::side_t            side4_reg;

    assign scl = (sraw3_reg >= (DW'(1) << (2 * F))) ? sraw3_reg : (DW'(1) << (2 * F));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_vortex)
        begin
            num4_reg[0] <= NW'(pys3_reg) << F;
            num4_reg[1] <= NW'(pxs3_reg) << F;
            den4_reg[1] <= scl;
        end
        else
        begin
            num4_reg[0] <= NW'(as_mag) << (2 * F);
            num4_reg[1] <= NW'(pxx3_reg) << (2 * F);
            den4_reg[1] <= sraw3_reg;
        end
        den4_reg[0]      <= scl;
        num4_reg[2]      <= NW'(pyy3_reg) << (2 * F);
        den4_reg[2]      <= sraw3_reg;
        side4_reg.zero   <= zero3_reg;
        side4_reg.beyond <= (rad_reg != '0) && (scl > DW'(r2_reg));
        side4_reg.neg_x  <= nx3_reg;
        side4_reg.neg_y  <= ny3_reg;
    end

    // three quotient lanes: scale or vortex x, unit x or vortex y, unit y
    logic                div_valid;
    logic [2:0][QW-1:0]  div_quo;
    logic [2:0]          div_ovf;

    ffe_div #(
        .NW    (NW),
        .DW    (DW),
        .QW    (QW),
        .LANES (3)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num       (num4_reg),
        .den       (den4_reg),
        .out_valid (div_valid),
        .quo       (div_quo),
        .ovf       (div_ovf)
    );

    // unit vector components
    logic                sq_valid;
    logic [1:0][RW-1:0]  sq_root;

    ffe_sqrt #(
        .VW    (QW),
        .LANES (2),
        .RW    (RW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .val       ({div_quo[2], div_quo[1]}),
        .out_valid (sq_valid),
        .root      (sq_root)
    );

    // quotients wait alongside the root pipeline, flags alongside the divider and root pipelines
    logic [2*QW+1:0] quo_d;
    logic [SW-1:0]   side_d;
    ffe_pkg::side_t  side5_in;

    ffe_delay #(
        .W (2 * QW + 2),
        .N (RW)
    ) u_quo_delay (
        .clk  (clk),
        .din  ({div_ovf[1], div_quo[1], div_ovf[0], div_quo[0]}),
        .dout (quo_d)
    );

    ffe_delay #(
        .W (SW),
        .N (1 + QW + RW)
    ) u_side_delay (
        .clk  (clk),
        .din  (side4_reg),
        .dout (side_d)
    );

    assign side5_in = ffe_pkg::side_t'(side_d);

    // stage 5: unit times scale
    logic            v5_reg;
    logic [MW-1:0]   mulx5_reg;
    logic [MW-1:0]   muly5_reg;
    logic [QW-1:0]   qa5_reg;
    logic [QW-1:0]   qb5_reg;
    logic            ova5_reg;
    logic            ovb5_reg;
    ffe_pkg::side_t  side5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mulx5_reg <= MW'(sq_root[0]) * MW'(quo_d[QW-1:0]);
        muly5_reg <= MW'(sq_root[1]) * MW'(quo_d[QW-1:0]);
        qa5_reg   <= quo_d[QW-1:0];
        ova5_reg  <= quo_d[QW];
        qb5_reg   <= quo_d[2*QW:QW+1];
        ovb5_reg  <= quo_d[2*QW+1];
        side5_reg <= side5_in;
    end

    // stage 6: saturate, sign and select the law
    logic [MW-1:0] mrx;
    logic [MW-1:0] mry;
    logic [MW-1:0] limx;
    logic [MW-1:0] limy;
    logic          bigx;
    logic          bigy;
    logic [MW-1:0] magx;
    logic [MW-1:0] magy;
    logic [CW-1:0] fx_next;
    logic [CW-1:0] fy_next;
    logic          clip_next;

    always_comb
    begin
        mrx  = is_vortex ? MW'(qa5_reg) : (mulx5_reg >> F);
        mry  = is_vortex ? MW'(qb5_reg) : (muly5_reg >> F);
        limx = side5_reg.neg_x ? (MW'(1) << (CW - 1)) : ((MW'(1) << (CW - 1)) - MW'(1));
        limy = side5_reg.neg_y ? (MW'(1) << (CW - 1)) : ((MW'(1) << (CW - 1)) - MW'(1));
        bigx = (is_vortex && ova5_reg) || (mrx > limx);
        bigy = (is_vortex && ovb5_reg) || (mry > limy);
        magx = bigx ? limx : mrx;
        magy = bigy ? limy : mry;
        if (is_const)
        begin
            fx_next   = ffx_reg;
            fy_next   = ffy_reg;
            clip_next = 1'b0;
        end
        else if ((!is_vortex && !is_radial) || side5_reg.zero ||
                 (is_radial && side5_reg.beyond))
        begin
            fx_next   = '0;
            fy_next   = '0;
            clip_next = 1'b0;
        end
        else
        begin
            fx_next   = side5_reg.neg_x ? CW'(-magx) : CW'(magx);
            fy_next   = side5_reg.neg_y ? CW'(-magy) : CW'(magy);
            clip_next = bigx || bigy;
        end
    end

    // result beat
    logic          done_reg;
    logic          clipped_reg;
    logic [CW-1:0] fx_reg;
    logic [CW-1:0] fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            clipped_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= v5_reg;
            clipped_reg <= v5_reg && clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg <= fx_next;
        fy_reg <= fy_next;
    end

    assign done    = done_reg;
    assign clipped = clipped_reg;
    assign force_x = fx_reg;
    assign force_y = fy_reg;

    // checks
    `FFE_ASSERT_IMPLY(a_done_latency, done, $past(start && !busy, LAT))
    `FFE_ASSERT_NEXT(a_stage5_to_done, v5_reg, done)
    `FFE_ASSERT_IMPLY(a_clip_with_done, clipped, done)
    `FFE_ASSERT_IMPLY(a_const_no_clip, done && is_const, !clipped)

endmodule
